@@ hdl/modulated_interpolating_delay_line_assert.svh @@
// Assertion macros for the modulated interpolating delay line
`ifndef MODULATED_INTERPOLATING_DELAY_LINE_ASSERT_SVH
`define MODULATED_INTERPOLATING_DELAY_LINE_ASSERT_SVH
`ifndef SYNTH
// Check a property on every rising clock edge outside reset
`define MIDL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition implies a consequence in the following cycle
`define MIDL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MIDL_ASSERT(label, prop, msg)
`define MIDL_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ hdl/midl_pkg.sv @@
// Shared constants for the modulated interpolating delay line
`timescale 1ns / 1ps
package midl_pkg;

  // Default ring size in samples
  localparam int DELAY_DEPTH_DEF = 4096;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int MOD_W    = 16;
  localparam int DEPTH_W  = 24;
  localparam int FRAC_W   = 16;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Configuration port
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = APB_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_DEPTH = '0;

endpackage

@@ hdl/modulated_interpolating_delay_line.sv @@
// Modulated fractional delay line with linear interpolation (top level)
// One word in flight at a time: a new input is accepted only when the sequencer is idle.
// The sequencer shares one multiplier (increment, then interpolation) and the single
//   read port of the ring RAM; it waits in its output state while the previous word is untaken.
// The output register holds a finished word while the next input is accepted.
// Reset: asynchronous, active low; clears pointer, delay, depth and fill count.
//   Ring entries not yet written since reset read as zero; no clearing pass.
`timescale 1ns / 1ps
`include "modulated_interpolating_delay_line_assert.svh"
module modulated_interpolating_delay_line #(
  parameter int DELAY_DEPTH = midl_pkg::DELAY_DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Input channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [midl_pkg::SAMPLE_W-1:0] input_sample_i,
  input  logic signed [midl_pkg::MOD_W-1:0]    modulator_sample_i,
  // Output channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [midl_pkg::SAMPLE_W-1:0] output_sample_o,
  // Configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [midl_pkg::APB_AW-1:0]          paddr,
  input  logic [midl_pkg::APB_DW-1:0]          pwdata,
  output logic [midl_pkg::APB_DW-1:0]          prdata,
  output logic                                 pready
);
  import midl_pkg::*;

  localparam int AW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int DW = AW + FRAC_W;
  localparam int IW = PROD_W - MOD_W + 1;
  localparam int SW = ((DW > IW) ? DW : IW) + 2;
  localparam int YW = PROD_W - FRAC_W + 1;

  localparam logic [AW-1:0] LAST_IDX  = AW'(DELAY_DEPTH - 1);
  localparam logic [DW-1:0] DMAX      = {LAST_IDX, {FRAC_W{1'b0}}};
  localparam logic [DW:0]   RING      = {(AW+1)'(DELAY_DEPTH), {FRAC_W{1'b0}}};
  localparam logic [AW:0]   FILL_FULL = (AW+1)'(DELAY_DEPTH);

  localparam logic signed [PROD_W-1:0] HALF_INC = PROD_W'(1) << (MOD_W - 2);
  localparam logic signed [PROD_W-1:0] HALF_OUT = PROD_W'(1) << (FRAC_W - 1);
  localparam logic signed [YW-1:0]     Y_MAX    = YW'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [YW-1:0]     Y_MIN    = YW'(-(1 << (SAMPLE_W - 1)));

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DLY  = 3'd1;
  localparam logic [2:0] S_POS  = 3'd2;
  localparam logic [2:0] S_RDB  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]                  state_q, state_d;
  logic signed [DEPTH_W-1:0]   depth_q;
  logic [AW-1:0]               wp_q;
  logic [DW-1:0]               delay_q;
  logic [AW:0]                 fill_q;
  logic signed [SAMPLE_W-1:0]  sample_q;
  logic signed [PROD_W-1:0]    prod_q;
  logic [AW-1:0]               ia_q, ib_q;
  logic [FRAC_W-1:0]           frac_q;
  logic signed [SAMPLE_W-1:0]  a_q;
  logic                        out_valid_q;
  logic signed [SAMPLE_W-1:0]  out_q;

  logic                        in_acc;
  logic                        out_acc;
  logic                        cfg_wr;
  logic [REG_IDX_W-1:0]        reg_idx;

  logic signed [MUL_A_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]    mul_p;

  logic signed [PROD_W-1:0]    inc_rnd;
  logic signed [IW-1:0]        inc;
  logic signed [SW-1:0]        dsum;
  logic [DW-1:0]               delay_d;

  logic [DW:0]                 pos_diff;
  logic [DW:0]                 pos_wrap;
  logic [AW-1:0]               ia_d, ib_d;

  logic [AW-1:0]               raddr;
  logic [SAMPLE_W-1:0]         rdata;
  logic signed [SAMPLE_W-1:0]  b_val;
  logic signed [SAMPLE_W:0]    diff;
  logic                        ram_we;

  logic signed [PROD_W-1:0]    out_rnd;
  logic signed [YW-1:0]        ysum;
  logic signed [SAMPLE_W-1:0]  y_sat;

  assign in_ready_o      = (state_q == S_IDLE);
  assign in_acc          = in_valid_i & in_ready_o;
  assign out_valid_o     = out_valid_q;
  assign output_sample_o = out_q;
  assign out_acc         = out_valid_q & out_ready_i;

  // Configuration access
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready & (reg_idx == REG_DEPTH);
  assign prdata  = (reg_idx == REG_DEPTH)
                 ? {{(APB_DW - DEPTH_W){depth_q[DEPTH_W-1]}}, depth_q} : '0;

  // Shared multiplier: modulator times depth, then slope times fraction
  always_comb begin
    if (state_q == S_MUL) begin
      mul_a = MUL_A_W'(signed'({1'b0, frac_q}));
      mul_b = MUL_B_W'(diff);
    end else begin
      mul_a = MUL_A_W'(depth_q);
      mul_b = MUL_B_W'(modulator_sample_i);
    end
  end
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Round the increment and clamp the running delay
  assign inc_rnd = prod_q + HALF_INC;
  assign inc     = inc_rnd[PROD_W-1:MOD_W-1];
  assign dsum    = SW'(signed'({1'b0, delay_q})) + SW'(inc);
  always_comb begin
    priority if (dsum[SW-1]) begin
      delay_d = '0;
    end else if (dsum > $signed(SW'(DMAX))) begin
      delay_d = DMAX;
    end else begin
      delay_d = dsum[DW-1:0];
    end
  end

  // Read position behind the write pointer, wrapped around the ring
  assign pos_diff = {1'b0, wp_q, {FRAC_W{1'b0}}} - {1'b0, delay_q};
  assign pos_wrap = pos_diff[DW] ? (pos_diff + RING) : pos_diff;
  assign ia_d     = pos_wrap[DW-1:FRAC_W];
  assign ib_d     = (ia_d == LAST_IDX) ? '0 : (ia_d + AW'(1));

  // Ring store; entries at or beyond the fill count read as zero
  assign raddr  = (state_q == S_POS) ? ia_d : ib_q;
  assign ram_we = (state_q == S_MUL);
  assign b_val  = ({1'b0, ib_q} < fill_q) ? signed'(rdata) : '0;
  assign diff   = (SAMPLE_W+1)'(b_val) - (SAMPLE_W+1)'(a_q);

  midl_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DELAY_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (sample_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Round the interpolated word and saturate
  assign out_rnd = prod_q + HALF_OUT;
  assign ysum    = YW'(a_q) + YW'(signed'(out_rnd[PROD_W-1:FRAC_W]));
  always_comb begin
    priority if (ysum > Y_MAX) begin
      y_sat = Y_MAX[SAMPLE_W-1:0];
    end else if (ysum < Y_MIN) begin
      y_sat = Y_MIN[SAMPLE_W-1:0];
    end else begin
      y_sat = ysum[SAMPLE_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_DLY;
      S_DLY:  state_d = S_POS;
      S_POS:  state_d = S_RDB;
      S_RDB:  state_d = S_MUL;
      S_MUL:  state_d = S_OUT;
      S_OUT:  if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      depth_q     <= '0;
      wp_q        <= '0;
      delay_q     <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        depth_q <= pwdata[DEPTH_W-1:0];
      end
      if (state_q == S_DLY) begin
        delay_q <= delay_d;
      end
      // Advance the write pointer and fill count after the store write
      if (ram_we) begin
        wp_q <= (wp_q == LAST_IDX) ? '0 : (wp_q + AW'(1));
        if (fill_q != FILL_FULL) begin
          fill_q <= fill_q + (AW+1)'(1);
        end
      end
      if ((state_q == S_OUT) && (state_d == S_IDLE)) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= input_sample_i;
      prod_q   <= mul_p;
    end
    if (state_q == S_POS) begin
      ia_q   <= ia_d;
      ib_q   <= ib_d;
      frac_q <= pos_wrap[FRAC_W-1:0];
    end
    // Hold the first tap, masked if never written
    if (state_q == S_RDB) begin
      a_q <= ({1'b0, ia_q} < fill_q) ? signed'(rdata) : '0;
    end
    if (state_q == S_MUL) begin
      prod_q <= mul_p;
    end
    if ((state_q == S_OUT) && (state_d == S_IDLE)) begin
      out_q <= y_sat;
    end
  end

  `MIDL_ASSERT(a_delay_range, delay_q <= DMAX, "delay left its range")
  `MIDL_ASSERT(a_fill_range, fill_q <= FILL_FULL, "fill count past ring size")
  `MIDL_ASSERT_NEXT(a_accept_seq, in_acc, state_q == S_DLY, "accept did not start sequence")
  `MIDL_ASSERT(a_out_source, $rose(out_valid_q) |-> $past(state_q) == S_OUT, "stray output word")
  `MIDL_ASSERT_NEXT(a_wp_step, ram_we && wp_q != LAST_IDX, wp_q == $past(wp_q) + AW'(1), "wp stuck")

endmodule

@@ hdl/midl_ram.sv @@
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module midl_ram #(
  parameter int WIDTH = midl_pkg::SAMPLE_W,
  parameter int DEPTH = midl_pkg::DELAY_DEPTH_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word, read one word per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
